@@ rtl/rau_pkg.sv @@
// Package for the rational arithmetic unit: operation codes, status and
// order codes, and the request struct for the shared iterative unit.
// No dependencies.
`timescale 1ns / 1ps

package rau_pkg;

  // fixed field widths of the ports
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CODE_W  = 2;

  // operation kinds on the input word
  localparam logic [KIND_W-1:0] KIND_REDUCE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMPARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd2;

  // status codes
  localparam logic [CODE_W-1:0] ST_OK       = 2'd0;
  localparam logic [CODE_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [CODE_W-1:0] ST_OVERFLOW = 2'd2;

  // compare results (two's complement)
  localparam logic [CODE_W-1:0] ORD_LESS    = 2'b11;
  localparam logic [CODE_W-1:0] ORD_EQUAL   = 2'b00;
  localparam logic [CODE_W-1:0] ORD_GREATER = 2'b01;

  // shared unit operations
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_GCD
  } op_e;

  // request from the sequencer to the shared unit
  typedef struct packed {
    logic go;
    op_e  op;
  } iter_req_t;

endpackage

@@ rtl/rau_iter.sv @@
// Shared iterative unit: shift-add multiply, restoring divide and binary gcd,
// one step per cycle on DW-bit unsigned operands.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_iter #(
  parameter int unsigned DW = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::iter_req_t req_i,
  input  logic [DW-1:0]     a_i,
  input  logic [DW-1:0]     b_i,
  output logic              done_o,
  output logic [DW-1:0]     res_o
);
  import rau_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  op_e           op_q;
  logic          busy_q;
  logic          done_q;
  logic [DW-1:0] x_q, x_d;
  logic [DW-1:0] y_q, y_d;
  logic [DW:0]   z_q, z_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] res_q, res_d;
  logic          fin;

  logic [DW:0]   rem_sh;
  logic [DW+1:0] dsub;
  logic [DW:0]   dxy;

  // one step of the selected operation
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    fin    = 1'b0;
    rem_sh = {z_q[DW-1:0], x_q[DW-1]};
    dsub   = {1'b0, rem_sh} - {2'b00, y_q};
    dxy    = {1'b0, x_q} - {1'b0, y_q};
    unique case (op_q)
      OP_MUL: begin
        if (y_q == '0) begin
          fin   = 1'b1;
          res_d = z_q[DW-1:0];
        end else begin
          if (y_q[0]) begin
            z_d = {1'b0, z_q[DW-1:0] + x_q};
          end
          x_d = {x_q[DW-2:0], 1'b0};
          y_d = {1'b0, y_q[DW-1:1]};
        end
      end
      OP_DIV: begin
        if (cnt_q == CW'(DW)) begin
          fin   = 1'b1;
          res_d = x_q;
        end else begin
          cnt_d = cnt_q + CW'(1);
          if (!dsub[DW+1]) begin
            z_d = dsub[DW:0];
            x_d = {x_q[DW-2:0], 1'b1};
          end else begin
            z_d = rem_sh;
            x_d = {x_q[DW-2:0], 1'b0};
          end
        end
      end
      OP_GCD: begin
        if (x_q == '0 || y_q == '0) begin
          fin   = 1'b1;
          res_d = (x_q | y_q) << cnt_q;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d   = {1'b0, x_q[DW-1:1]};
          y_d   = {1'b0, y_q[DW-1:1]};
          cnt_d = cnt_q + CW'(1);
        end else if (!x_q[0]) begin
          x_d = {1'b0, x_q[DW-1:1]};
        end else if (!y_q[0]) begin
          y_d = {1'b0, y_q[DW-1:1]};
        end else if (!dxy[DW]) begin
          x_d = dxy[DW-1:0];
        end else begin
          y_d = y_q - x_q;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
      end else if (busy_q && fin) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      x_q   <= a_i;
      y_q   <= b_i;
      z_q   <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      cnt_q <= cnt_d;
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: reduce, compare and add of WIDTH-bit fractions.
// All three run their steps on the shared multiply/divide/gcd unit.
// One word in flight; the next word is taken once the result is registered.
// Reset (async, active low) clears the sequencer, the shared unit's control and output valid only.
// Depends on rau_pkg and rau_iter.
`timescale 1ns / 1ps

module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rau_pkg::KIND_W-1:0]       kind_i,
  input  logic signed [rau_pkg::FIELD_W-1:0] num_a_i,
  input  logic signed [rau_pkg::FIELD_W-1:0] den_a_i,
  input  logic signed [rau_pkg::FIELD_W-1:0] num_b_i,
  input  logic signed [rau_pkg::FIELD_W-1:0] den_b_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [rau_pkg::FIELD_W-1:0] num_out_o,
  output logic signed [rau_pkg::FIELD_W-1:0] den_out_o,
  output logic signed [rau_pkg::CODE_W-1:0]  order_o,
  output logic [rau_pkg::CODE_W-1:0]       status_o
);
  import rau_pkg::*;

  localparam int unsigned DW = 2 * WIDTH;
  localparam logic [DW-1:0] MAXPOS = (DW'(1) << (WIDTH - 1)) - DW'(1);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CMP_M1 = 4'd1;
  localparam logic [3:0] S_CMP_M2 = 4'd2;
  localparam logic [3:0] S_ADD_G  = 4'd3;
  localparam logic [3:0] S_ADD_DX = 4'd4;
  localparam logic [3:0] S_ADD_DY = 4'd5;
  localparam logic [3:0] S_ADD_ML = 4'd6;
  localparam logic [3:0] S_ADD_M1 = 4'd7;
  localparam logic [3:0] S_ADD_M2 = 4'd8;
  localparam logic [3:0] S_FIN_G  = 4'd9;
  localparam logic [3:0] S_FIN_DN = 4'd10;
  localparam logic [3:0] S_FIN_DD = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state_q, state_d;
  logic       issued_q;

  // operand store
  logic             sna_q, sda_q, snb_q, sdb_q;
  logic [WIDTH-1:0] mna_q, mda_q, mnb_q, mdb_q;
  logic [DW-1:0]    g_q, x_q, y_q, t1_q;
  logic [DW-1:0]    nm_q, dm_q;
  logic             neg_q;

  // pending result and output register
  logic [FIELD_W-1:0] res_num_q, res_den_q;
  logic [CODE_W-1:0]  res_ord_q, res_st_q;
  logic               out_valid_q;
  logic [FIELD_W-1:0] out_num_q, out_den_q;
  logic [CODE_W-1:0]  out_ord_q, out_st_q;

  // shared unit
  iter_req_t     req;
  logic [DW-1:0] op_a, op_b;
  logic          it_done;
  logic [DW-1:0] it_res;

  // input decode
  logic             accept;
  logic             in_sna, in_sda, in_snb, in_sdb;
  logic [WIDTH-1:0] in_mna, in_mda, in_mnb, in_mdb;
  logic             in_za, in_zb;
  logic signed [WIDTH-1:0] in_na_s;

  assign accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_sna  = num_a_i[WIDTH-1];
  assign in_sda  = den_a_i[WIDTH-1];
  assign in_snb  = num_b_i[WIDTH-1];
  assign in_sdb  = den_b_i[WIDTH-1];
  assign in_mna  = in_sna ? -num_a_i[WIDTH-1:0] : num_a_i[WIDTH-1:0];
  assign in_mda  = in_sda ? -den_a_i[WIDTH-1:0] : den_a_i[WIDTH-1:0];
  assign in_mnb  = in_snb ? -num_b_i[WIDTH-1:0] : num_b_i[WIDTH-1:0];
  assign in_mdb  = in_sdb ? -den_b_i[WIDTH-1:0] : den_b_i[WIDTH-1:0];
  assign in_za   = (den_a_i[WIDTH-1:0] == '0);
  assign in_zb   = (den_b_i[WIDTH-1:0] == '0);
  assign in_na_s = num_a_i[WIDTH-1:0];

  // operand select for the shared unit
  always_comb begin
    req.go = 1'b0;
    req.op = OP_MUL;
    op_a   = '0;
    op_b   = '0;
    unique case (state_q)
      S_CMP_M1: begin req.op = OP_MUL; op_a = DW'(mna_q); op_b = DW'(mdb_q); end
      S_CMP_M2: begin req.op = OP_MUL; op_a = DW'(mnb_q); op_b = DW'(mda_q); end
      S_ADD_G:  begin req.op = OP_GCD; op_a = DW'(mda_q); op_b = DW'(mdb_q); end
      S_ADD_DX: begin req.op = OP_DIV; op_a = DW'(mda_q); op_b = g_q;        end
      S_ADD_DY: begin req.op = OP_DIV; op_a = DW'(mdb_q); op_b = g_q;        end
      S_ADD_ML: begin req.op = OP_MUL; op_a = x_q;        op_b = DW'(mdb_q); end
      S_ADD_M1: begin req.op = OP_MUL; op_a = DW'(mna_q); op_b = y_q;        end
      S_ADD_M2: begin req.op = OP_MUL; op_a = DW'(mnb_q); op_b = x_q;        end
      S_FIN_G:  begin req.op = OP_GCD; op_a = nm_q;       op_b = dm_q;       end
      S_FIN_DN: begin req.op = OP_DIV; op_a = nm_q;       op_b = g_q;        end
      S_FIN_DD: begin req.op = OP_DIV; op_a = dm_q;       op_b = g_q;        end
      default: ;
    endcase
    req.go = (state_q != S_IDLE) && (state_q != S_OUT) && !issued_q
             && !(state_q == S_FIN_G && nm_q == '0);
  end

  rau_iter #(
    .DW (DW)
  ) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (it_done),
    .res_o  (it_res)
  );

  // finishing: wrap, sign-extend and range check
  logic [DW-1:0]           fin_dm, fin_sv;
  logic                    fin_neg;
  logic signed [WIDTH-1:0] fin_num_w, fin_den_w;
  logic                    fin_fits;

  always_comb begin
    fin_dm    = (state_q == S_FIN_DD) ? it_res : dm_q;
    fin_neg   = neg_q && (nm_q != '0);
    fin_sv    = fin_neg ? -nm_q : nm_q;
    fin_num_w = fin_sv[WIDTH-1:0];
    fin_den_w = fin_dm[WIDTH-1:0];
    fin_fits  = (fin_dm <= MAXPOS) &&
                ((nm_q <= MAXPOS) || (fin_neg && nm_q == MAXPOS + DW'(1)));
  end

  // compare of the two signed cross products
  logic signed [DW:0] cmp_pa, cmp_pb;
  logic [CODE_W-1:0]  cmp_ord;

  always_comb begin
    cmp_pa = (sna_q ^ sda_q) ? -$signed({1'b0, t1_q})   : $signed({1'b0, t1_q});
    cmp_pb = (snb_q ^ sdb_q) ? -$signed({1'b0, it_res}) : $signed({1'b0, it_res});
    priority if (cmp_pa == cmp_pb) begin
      cmp_ord = ORD_EQUAL;
    end else if (cmp_pa > cmp_pb) begin
      cmp_ord = ORD_GREATER;
    end else begin
      cmp_ord = ORD_LESS;
    end
  end

  // signed sum of the scaled numerators
  logic          add_s1, add_s2, add_neg;
  logic [DW-1:0] add_sm;

  always_comb begin
    add_s1 = sna_q ^ sda_q;
    add_s2 = snb_q ^ sdb_q;
    priority if (add_s1 == add_s2) begin
      add_neg = add_s1;
      add_sm  = t1_q + it_res;
    end else if (t1_q >= it_res) begin
      add_neg = add_s1;
      add_sm  = t1_q - it_res;
    end else begin
      add_neg = add_s2;
      add_sm  = it_res - t1_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (kind_i == KIND_REDUCE && !in_za) begin
            state_d = S_FIN_G;
          end else if (kind_i == KIND_COMPARE && !in_za && !in_zb) begin
            state_d = S_CMP_M1;
          end else if (kind_i == KIND_ADD && !in_za && !in_zb) begin
            state_d = S_ADD_G;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_CMP_M1: if (it_done) state_d = S_CMP_M2;
      S_CMP_M2: if (it_done) state_d = S_OUT;
      S_ADD_G:  if (it_done) state_d = S_ADD_DX;
      S_ADD_DX: if (it_done) state_d = S_ADD_DY;
      S_ADD_DY: if (it_done) state_d = S_ADD_ML;
      S_ADD_ML: if (it_done) state_d = S_ADD_M1;
      S_ADD_M1: if (it_done) state_d = S_ADD_M2;
      S_ADD_M2: if (it_done) state_d = S_FIN_G;
      S_FIN_G: begin
        if (nm_q == '0) begin
          state_d = S_OUT;
        end else if (it_done) begin
          state_d = S_FIN_DN;
        end
      end
      S_FIN_DN: if (it_done) state_d = S_FIN_DD;
      S_FIN_DD: if (it_done) state_d = S_OUT;
      S_OUT:    if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req.go) begin
        issued_q <= 1'b1;
      end else if (it_done) begin
        issued_q <= 1'b0;
      end
      if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sna_q     <= in_sna;
      sda_q     <= in_sda;
      snb_q     <= in_snb;
      sdb_q     <= in_sdb;
      mna_q     <= in_mna;
      mda_q     <= in_mda;
      mnb_q     <= in_mnb;
      mdb_q     <= in_mdb;
      nm_q      <= DW'(in_mna);
      dm_q      <= DW'(in_mda);
      neg_q     <= in_sna ^ in_sda;
      res_num_q <= '0;
      res_den_q <= '0;
      res_ord_q <= ORD_EQUAL;
      res_st_q  <= ST_INVALID;
      // zero denominator on reduce passes the numerator through
      if (kind_i == KIND_REDUCE && in_za) begin
        res_num_q <= FIELD_W'(in_na_s);
      end
    end
    if (it_done) begin
      unique case (state_q)
        S_CMP_M1: t1_q <= it_res;
        S_CMP_M2: begin
          res_ord_q <= cmp_ord;
          res_st_q  <= ST_OK;
        end
        S_ADD_G:  g_q  <= it_res;
        S_ADD_DX: x_q  <= it_res;
        S_ADD_DY: y_q  <= it_res;
        S_ADD_ML: dm_q <= it_res;
        S_ADD_M1: t1_q <= it_res;
        S_ADD_M2: begin
          nm_q  <= add_sm;
          neg_q <= add_neg;
        end
        S_FIN_G:  g_q  <= it_res;
        S_FIN_DN: nm_q <= it_res;
        default: ;
      endcase
    end
    // finished fraction, with or without a common factor removed
    if ((state_q == S_FIN_DD && it_done) || (state_q == S_FIN_G && nm_q == '0)) begin
      res_num_q <= FIELD_W'(fin_num_w);
      res_den_q <= FIELD_W'(fin_den_w);
      res_ord_q <= ORD_EQUAL;
      res_st_q  <= fin_fits ? ST_OK : ST_OVERFLOW;
    end
    if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
      out_num_q <= res_num_q;
      out_den_q <= res_den_q;
      out_ord_q <= res_ord_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign num_out_o   = out_num_q;
  assign den_out_o   = out_den_q;
  assign order_o     = out_ord_q;
  assign status_o    = out_st_q;

  // a taken word raises the input stall
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input not blocked after accept");

  // the shared unit reports only work that the sequencer issued
  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_done |-> issued_q)
    else $error("unit done without a request");

  // a good fraction result carries a positive denominator
  a_den_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK && den_out_o != '0 |-> !den_out_o[FIELD_W-1])
    else $error("negative denominator with good status");

endmodule
